### rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PRIO_W       = 16;
  localparam int unsigned COUNT_W      = 5;

  localparam logic [DATA_W-1:0] EMPTY_DATA = DATA_W'(-100);
  localparam logic [PRIO_W-1:0] EMPTY_PRIO = PRIO_W'(-100);

  // Operation codes on kind
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  // Command broadcast to every cell in the cycle of a transfer
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [DATA_W-1:0] data;
    logic [PRIO_W-1:0] prio;
  } spq_cmd_t;

endpackage

### rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares, shifts or takes the new item.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_cmd_t   cmd_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic              left_gt_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic              gt_o
);
  import spq_pkg::*;

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic              gt;

  // Strictly greater keeps equal priorities in arrival order
  assign gt = valid_q && ($signed(prio_q) > $signed(cmd_i.prio));

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (cmd_i.enq) begin
      if (left_gt_i) begin
        // left entry moves one place towards the tail
        valid_d = left_i.valid;
        data_d  = left_i.data;
        prio_d  = left_i.prio;
      end else if (valid_q ? gt : left_i.valid) begin
        valid_d = 1'b1;
        data_d  = cmd_i.data;
        prio_d  = cmd_i.prio;
      end
    end else if (cmd_i.deq) begin
      valid_d = right_i.valid;
      data_d  = right_i.data;
      prio_d  = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign entry_o = '{valid: valid_q, data: data_q, prio: prio_q};
  assign gt_o    = gt;

endmodule

### rtl/stable_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue held as a sorted chain of cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// command  in         start_i, busy_o         kind_i, item_data_i, item_priority_i
// result   out        done_o (one cycle)      head_*_o, not_empty_o, entry_count_o,
//                                             refused_full_o, empty_pop_o
//
// A command is transferred at any edge with start_i high; busy_o stays low.
// Every cell compares against the new priority in parallel and shifts in the
// same cycle, so one command per cycle is taken and its result shows done_o in the
// cycle after the transfer. Reset empties the queue at once.
// The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
  parameter int unsigned Capacity = spq_pkg::CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [spq_pkg::DATA_W-1:0]  item_data_i,
  input  logic [spq_pkg::PRIO_W-1:0]  item_priority_i,
  output logic                        done_o,
  output logic [spq_pkg::DATA_W-1:0]  head_data_o,
  output logic [spq_pkg::PRIO_W-1:0]  head_priority_o,
  output logic                        not_empty_o,
  output logic [spq_pkg::COUNT_W-1:0] entry_count_o,
  output logic                        refused_full_o,
  output logic                        empty_pop_o
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  spq_entry_t          entry [Capacity];
  logic [Capacity-1:0] gt;
  spq_cmd_t            cmd;
  logic                full, empty, xfer;
  logic [CntW-1:0]     count_q, count_d;
  logic                done_q, refused_q, empty_pop_q;
  logic [CntW+COUNT_W-1:0] count_ext;

  assign busy_o = 1'b0;
  assign xfer   = start_i && !busy_o;
  assign full   = entry[Capacity-1].valid;
  assign empty  = !entry[0].valid;

  assign cmd.enq  = xfer && (kind_i == KIND_ENQ) && !full;
  assign cmd.deq  = xfer && (kind_i == KIND_DEQ) && !empty;
  assign cmd.data = item_data_i;
  assign cmd.prio = item_priority_i;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    spq_entry_t left, right;
    logic       left_gt;
    if (i == 0) begin : g_head
      // an always-valid, never-greater neighbour lets the head take the item
      assign left    = '{valid: 1'b1, data: '0, prio: '0};
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left    = entry[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == Capacity - 1) begin : g_tail
      assign right = '{valid: 1'b0, data: '0, prio: '0};
    end else begin : g_mid
      assign right = entry[i+1];
    end
    spq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .left_i   (left),
      .left_gt_i(left_gt),
      .right_i  (right),
      .entry_o  (entry[i]),
      .gt_o     (gt[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      done_q      <= 1'b0;
      refused_q   <= 1'b0;
      empty_pop_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      done_q      <= xfer;
      refused_q   <= xfer && (kind_i == KIND_ENQ) && full;
      empty_pop_q <= xfer && (kind_i == KIND_DEQ) && empty;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_q};

  assign done_o          = done_q;
  assign head_data_o     = empty ? EMPTY_DATA : entry[0].data;
  assign head_priority_o = empty ? EMPTY_PRIO : entry[0].prio;
  assign not_empty_o     = !empty;
  assign entry_count_o   = count_ext[COUNT_W-1:0];
  assign refused_full_o  = refused_q;
  assign empty_pop_o     = empty_pop_q;

endmodule

### rtl/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned Capacity = spq_pkg::CAPACITY_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [spq_pkg::DATA_W-1:0]  head_data_o,
  input logic [spq_pkg::PRIO_W-1:0]  head_priority_o,
  input logic                        not_empty_o,
  input logic [spq_pkg::COUNT_W-1:0] entry_count_o,
  input logic                        refused_full_o,
  input logic                        empty_pop_o
);
  import spq_pkg::*;

  // each transfer yields exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("missing result after transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without transfer");

  a_empty_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !not_empty_o) |->
      (head_data_o == EMPTY_DATA) && (head_priority_o == EMPTY_PRIO))
    else $error("empty queue head not marked");

  // a refused enqueue leaves a full queue and never comes with an empty pop
  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && refused_full_o) |->
      !empty_pop_o && not_empty_o && (entry_count_o == COUNT_W'(Capacity)))
    else $error("refused enqueue on a queue that is not full");

  a_empty_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && empty_pop_o) |-> (entry_count_o == '0) && !not_empty_o)
    else $error("empty pop on non-empty queue");

endmodule

bind stable_priority_queue_unit spq_checker #(.Capacity(Capacity)) u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .head_data_o    (head_data_o),
  .head_priority_o(head_priority_o),
  .not_empty_o    (not_empty_o),
  .entry_count_o  (entry_count_o),
  .refused_full_o (refused_full_o),
  .empty_pop_o    (empty_pop_o)
);

### dv/tb_stable_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_unit
// Self-checking bench for the bounded stable priority queue. A short table of
// directed commands covers the field extremes, equal-priority ordering, the
// empty-queue dequeue and the full-queue enqueue. Random command bursts then
// fill and drain the queue under varying sender gaps. Every report is checked
// field by field against its typed row or else the bench's sorted-list model.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_unit;
  import spq_pkg::*;

  localparam int DIR_ROWS      = 25;
  localparam int ITEMS_PER_RUN = 300;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [DATA_W-1:0]  head_data;
    logic [PRIO_W-1:0]  head_prio;
    logic               not_empty;
    logic [COUNT_W-1:0] count;
    logic               refused_full;
    logic               empty_pop;
  } head_report_t;

  typedef struct {
    logic         kind;
    logic [31:0]  data;
    logic [15:0]  prio;
    bit           typed;
    head_report_t report;
  } cmd_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                kind_i;
  logic [DATA_W-1:0]   item_data_i;
  logic [PRIO_W-1:0]   item_priority_i;
  wire                 busy_o;
  wire                 done_o;
  wire  [DATA_W-1:0]   head_data_o;
  wire  [PRIO_W-1:0]   head_priority_o;
  wire                 not_empty_o;
  wire  [COUNT_W-1:0]  entry_count_o;
  wire                 refused_full_o;
  wire                 empty_pop_o;

  // Sorted contents of the queue as the bench sees it, head at index 0
  logic        [DATA_W-1:0] queue_data[$];
  logic signed [PRIO_W-1:0] queue_prio[$];
  head_report_t             pending_reports[$];
  cmd_row_t                 dir_rows[DIR_ROWS];
  int                       fail_count;
  int                       cycle_count;

  stable_priority_queue_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .kind_i          (kind_i),
    .item_data_i     (item_data_i),
    .item_priority_i (item_priority_i),
    .done_o          (done_o),
    .head_data_o     (head_data_o),
    .head_priority_o (head_priority_o),
    .not_empty_o     (not_empty_o),
    .entry_count_o   (entry_count_o),
    .refused_full_o  (refused_full_o),
    .empty_pop_o     (empty_pop_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one command to the queue model and return the report it yields
  function automatic head_report_t queue_apply(input logic kind, input logic [DATA_W-1:0] data,
                                               input logic [PRIO_W-1:0] prio);
    head_report_t rep;
    int           pos;
    rep = '0;
    if (kind == KIND_ENQ) begin
      if (queue_data.size() >= CAPACITY_DEF) begin
        rep.refused_full = 1'b1;
      end else begin
        // place after every entry of lower or equal priority
        pos = queue_data.size();
        for (int i = 0; i < queue_data.size(); i++) begin
          if (queue_prio[i] > $signed(prio)) begin
            pos = i;
            break;
          end
        end
        queue_data.insert(pos, data);
        queue_prio.insert(pos, prio);
      end
    end else begin
      if (queue_data.size() == 0) begin
        rep.empty_pop = 1'b1;
      end else begin
        void'(queue_data.pop_front());
        void'(queue_prio.pop_front());
      end
    end
    if (queue_data.size() > 0) begin
      rep.head_data = queue_data[0];
      rep.head_prio = queue_prio[0];
      rep.not_empty = 1'b1;
    end else begin
      rep.head_data = EMPTY_DATA;
      rep.head_prio = EMPTY_PRIO;
      rep.not_empty = 1'b0;
    end
    rep.count = COUNT_W'(queue_data.size());
    return rep;
  endfunction

  // Present one command, hold it until transferred, then record its report
  task automatic send_cmd(input logic kind, input logic [DATA_W-1:0] data,
                          input logic [PRIO_W-1:0] prio, input bit typed,
                          input head_report_t typed_report, input int idle_pct);
    head_report_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    kind_i          <= kind;
    item_data_i     <= data;
    item_priority_i <= prio;
    do @(posedge clk_i); while (busy_o);
    predicted = queue_apply(kind, data, prio);
    pending_reports.insert(pending_reports.size(), typed ? typed_report : predicted);
  endtask

  function automatic logic [PRIO_W-1:0] pick_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(3))
      0: p = PRIO_W'($urandom);
      1: p = PRIO_W'($urandom_range(4)) - PRIO_W'(2);   // dense ties around zero
      2: begin
        case ($urandom_range(2))
          0: p = 16'h8000;
          1: p = 16'h7FFF;
          default: p = EMPTY_PRIO;
        endcase
      end
      default: p = PRIO_W'($urandom_range(40)) - PRIO_W'(20);
    endcase
    return p;
  endfunction

  task automatic check_report(input head_report_t exp);
    if (head_data_o !== exp.head_data)
      $error("head_data: expected %0d, actual %0d", $signed(exp.head_data),
             $signed(head_data_o));
    if (head_priority_o !== exp.head_prio)
      $error("head_priority: expected %0d, actual %0d", $signed(exp.head_prio),
             $signed(head_priority_o));
    if (not_empty_o !== exp.not_empty)
      $error("not_empty: expected %0d, actual %0d", exp.not_empty, not_empty_o);
    if (entry_count_o !== exp.count)
      $error("entry_count: expected %0d, actual %0d", exp.count, entry_count_o);
    if (refused_full_o !== exp.refused_full)
      $error("refused_full: expected %0d, actual %0d", exp.refused_full, refused_full_o);
    if (empty_pop_o !== exp.empty_pop)
      $error("empty_pop: expected %0d, actual %0d", exp.empty_pop, empty_pop_o);
    if (head_data_o !== exp.head_data || head_priority_o !== exp.head_prio ||
        not_empty_o !== exp.not_empty || entry_count_o !== exp.count ||
        refused_full_o !== exp.refused_full || empty_pop_o !== exp.empty_pop)
      fail_count++;
  endtask

  // Sample reports on the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: head_data %0d, entry_count %0d",
               $signed(head_data_o), entry_count_o);
        fail_count++;
      end else begin
        check_report(pending_reports.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          enq_pct;
    int          idle_pct;
    logic        kind;
    logic [31:0] data;
    fail_count      = 0;
    cycle_count     = 0;
    rst_ni          <= 1'b0;
    start_i         <= 1'b0;
    kind_i          <= KIND_ENQ;
    item_data_i     <= '0;
    item_priority_i <= '0;

    dir_rows = '{
      '{KIND_DEQ, 32'h0000_0000, 16'h0000, 1'b1,
        '{EMPTY_DATA, EMPTY_PRIO, 1'b0, 5'd0, 1'b0, 1'b1}},
      '{KIND_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b1,
        '{32'h7FFF_FFFF, 16'h7FFF, 1'b1, 5'd1, 1'b0, 1'b0}},
      '{KIND_ENQ, 32'h8000_0000, 16'h8000, 1'b1,
        '{32'h8000_0000, 16'h8000, 1'b1, 5'd2, 1'b0, 1'b0}},
      '{KIND_ENQ, 32'h0000_0005, 16'h8000, 1'b1,
        '{32'h8000_0000, 16'h8000, 1'b1, 5'd3, 1'b0, 1'b0}},
      '{KIND_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        '{32'h0000_0005, 16'h8000, 1'b1, 5'd2, 1'b0, 1'b0}},
      '{KIND_DEQ, 32'h0000_0000, 16'h0000, 1'b1,
        '{32'h7FFF_FFFF, 16'h7FFF, 1'b1, 5'd1, 1'b0, 1'b0}},
      '{KIND_DEQ, 32'h0000_0000, 16'h0000, 1'b1,
        '{EMPTY_DATA, EMPTY_PRIO, 1'b0, 5'd0, 1'b0, 1'b0}},
      '{KIND_ENQ, EMPTY_DATA,    EMPTY_PRIO, 1'b1,
        '{EMPTY_DATA, EMPTY_PRIO, 1'b1, 5'd1, 1'b0, 1'b0}},
      '{KIND_ENQ, 32'h0000_0009, 16'h8000, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_000A, 16'h0000, 1'b0, '0},
      '{KIND_ENQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
      '{KIND_ENQ, 32'h5555_5555, 16'h7FFF, 1'b0, '0},
      '{KIND_ENQ, 32'hAAAA_AAAA, 16'h8000, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_000E, EMPTY_PRIO, 1'b0, '0},
      '{KIND_ENQ, 32'h1234_5678, 16'h0003, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_0010, 16'h0003, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_0011, 16'h0003, 1'b0, '0},
      '{KIND_ENQ, 32'h8765_4321, 16'h0001, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_0013, 16'h0002, 1'b0, '0},
      '{KIND_ENQ, 32'h7FFF_FFFF, 16'h5555, 1'b0, '0},
      '{KIND_ENQ, 32'h8000_0000, 16'hAAAA, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_0016, 16'h0000, 1'b0, '0},
      '{KIND_ENQ, 32'h0000_0017, 16'h7FFF, 1'b0, '0},
      '{KIND_ENQ, 32'hDEAD_BEEF, 16'h8000, 1'b1,
        '{32'h0000_0009, 16'h8000, 1'b1, 5'd16, 1'b1, 1'b0}},
      '{KIND_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r])
      send_cmd(dir_rows[r].kind, dir_rows[r].data, dir_rows[r].prio, dir_rows[r].typed,
               dir_rows[r].report, 16);

    for (int run = 0; run < 3; run++) begin
      case (run)
        0: idle_pct = 16;
        1: idle_pct = 79;
        default: idle_pct = 0;
      endcase
      enq_pct = 75;
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        // swing between filling and draining bursts to visit full and empty
        if (n % 32 == 0) begin
          case ($urandom_range(2))
            0: enq_pct = 80;
            1: enq_pct = 20;
            default: enq_pct = 50;
          endcase
        end
        kind = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        data = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                                        : $urandom;
        send_cmd(kind, data, pick_prio(), 1'b0, '0, idle_pct);
      end
    end

    start_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_unit.sv
rtl/spq_checker.sv
dv/tb_stable_priority_queue_unit.sv
